FILE: sv/sqvg_pkg.sv
// ----------------------------------------------------------------------------
// sqvg_pkg
// Types and constants shared by the sphere vertex generator and its cells,
// and the arctangent table used by the CORDIC cells.
// ----------------------------------------------------------------------------
package sqvg_pkg;

  localparam int unsigned MaxSteps = 1024;
  localparam int unsigned StepW    = 11;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned DivW     = 43;
  localparam int unsigned RemW     = 11;

  localparam logic signed [31:0] CordicOne = 32'sd652032874;

  typedef enum logic [2:0] {
    REG_RADIUS    = 3'd0,
    REG_CENTER_X  = 3'd1,
    REG_CENTER_Y  = 3'd2,
    REG_CENTER_Z  = 3'd3,
    REG_VERT_STEP = 3'd4,
    REG_RAD_STEP  = 3'd5,
    REG_AZ_OFFSET = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [IdxW-1:0] ring_index;
    logic [IdxW-1:0] band_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               last_corner;
  } out_item_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DivW-1:0] word;
  } div_lane_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [33:0] z;
  } rot_t;

  typedef struct packed {
    logic [1:0]  corner;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic        neg_lat;
    logic        neg_az;
  } cor_tag_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] r;
    case (k)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12e4051d;
      5'd2:    r = 32'h09fb385b;
      5'd3:    r = 32'h051111d4;
      5'd4:    r = 32'h028b0d43;
      5'd5:    r = 32'h0145d7e1;
      5'd6:    r = 32'h00a2f61e;
      5'd7:    r = 32'h00517c55;
      5'd8:    r = 32'h0028be53;
      5'd9:    r = 32'h00145f2e;
      5'd10:   r = 32'h000a2f98;
      5'd11:   r = 32'h000517cc;
      5'd12:   r = 32'h00028be6;
      5'd13:   r = 32'h000145f3;
      5'd14:   r = 32'h0000a2f9;
      5'd15:   r = 32'h0000517c;
      5'd16:   r = 32'h000028be;
      5'd17:   r = 32'h0000145f;
      5'd18:   r = 32'h00000a2f;
      5'd19:   r = 32'h00000517;
      5'd20:   r = 32'h0000028b;
      5'd21:   r = 32'h00000145;
      5'd22:   r = 32'h000000a2;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/sqvg_stream_if.sv
// ----------------------------------------------------------------------------
// sqvg_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface sqvg_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input ready, input data);
endinterface

FILE: sv/sqvg_div_cell.sv
// ----------------------------------------------------------------------------
// sqvg_div_cell
// One restoring-division step for the azimuth and latitude quotients.
// ----------------------------------------------------------------------------
module sqvg_div_cell import sqvg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [StepW-1:0] d_az_i,
  input  logic [StepW-1:0] d_lat_i,
  input  logic             valid_i,
  input  logic [1:0]       corner_i,
  input  div_lane_t        az_i,
  input  div_lane_t        lat_i,
  output logic             valid_o,
  output logic [1:0]       corner_o,
  output div_lane_t        az_o,
  output div_lane_t        lat_o
);

  function automatic div_lane_t div_step(input div_lane_t a, input logic [StepW-1:0] d);
    logic [RemW:0] t;
    div_lane_t     r;
    t      = {a.rem, a.word[DivW-1]};
    r.word = {a.word[DivW-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      t         = t - {1'b0, d};
      r.word[0] = 1'b1;
    end
    r.rem = t[RemW-1:0];
    return r;
  endfunction

  logic      valid_q;
  logic [1:0] corner_q;
  div_lane_t az_q, lat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      corner_q <= corner_i;
      az_q     <= div_step(az_i, d_az_i);
      lat_q    <= div_step(lat_i, d_lat_i);
    end
  end

  assign valid_o  = valid_q;
  assign corner_o = corner_q;
  assign az_o     = az_q;
  assign lat_o    = lat_q;

endmodule

FILE: sv/sqvg_cordic_cell.sv
// ----------------------------------------------------------------------------
// sqvg_cordic_cell
// One CORDIC rotation for the latitude and azimuth angles.
// ----------------------------------------------------------------------------
module sqvg_cordic_cell import sqvg_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  cor_tag_t tag_i,
  input  rot_t     lat_i,
  input  rot_t     az_i,
  output logic     valid_o,
  output cor_tag_t tag_o,
  output rot_t     lat_o,
  output rot_t     az_o
);

  function automatic rot_t rotate(input rot_t a);
    rot_t              r;
    logic signed [33:0] ang;
    ang = $signed({2'b00, atan_turn(5'(STAGE))});
    if (!a.z[33]) begin
      r.x = a.x - (a.y >>> STAGE);
      r.y = a.y + (a.x >>> STAGE);
      r.z = a.z - ang;
    end else begin
      r.x = a.x + (a.y >>> STAGE);
      r.y = a.y - (a.x >>> STAGE);
      r.z = a.z + ang;
    end
    return r;
  endfunction

  logic     valid_q;
  cor_tag_t tag_q;
  rot_t     lat_q, az_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q <= tag_i;
      lat_q <= rotate(lat_i);
      az_q  <= rotate(az_i);
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign lat_o   = lat_q;
  assign az_o    = az_q;

endmodule

FILE: sv/sphere_quad_vertex_generator.sv
// ----------------------------------------------------------------------------
// sphere_quad_vertex_generator
// Emits the four corners of one latitude-longitude sphere quad per input beat.
// ----------------------------------------------------------------------------
// Each quad beat yields four corner beats, one per cycle while the output is
// not stalled; the corner sequencer takes the next quad while it issues the
// last corner of the current one. Corners pass through a 43-cell division
// chain, a chain of CORDIC_STAGES rotation cells and four arithmetic stages.
// A stalled output holds the whole pipeline.
module sphere_quad_vertex_generator import sqvg_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  sqvg_stream_if.sink   in_if,
  sqvg_stream_if.source out_if
);

  function automatic logic [StepW-1:0] eff_steps(input logic [StepW-1:0] s);
    logic [StepW-1:0] r;
    r = s;
    if (s == '0) begin
      r = StepW'(1);
    end else if ({6'b0, s} > 17'(MaxSteps)) begin
      r = StepW'(MaxSteps);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp30(input logic signed [31:0] v, input logic neg);
    logic signed [31:0] t;
    t = neg ? -v : v;
    if (t > 32'sd1073741824) begin
      t = 32'sd1073741824;
    end else if (t < -32'sd1073741824) begin
      t = -32'sd1073741824;
    end
    return t;
  endfunction

  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = (a * b + 64'sd536870912) >>> 30;
    return p[31:0];
  endfunction

  function automatic logic signed [31:0] pos_sat(input logic signed [63:0] prod,
                                                  input logic signed [31:0] ctr);
    logic signed [63:0] sh;
    logic signed [34:0] s;
    logic signed [31:0] r;
    sh = (prod + 64'sd536870912) >>> 30;
    s  = 35'(sh) + 35'(ctr);
    if (s > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (s < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] norm_sat(input logic signed [31:0] p);
    logic signed [31:0] n;
    logic signed [15:0] r;
    n = (p + 32'sd16384) >>> 15;
    if (n > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (n < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = n[15:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [30:0]        radius_q;
  logic signed [31:0] center_x_q, center_y_q, center_z_q;
  logic [StepW-1:0]   vert_steps_q, rad_steps_q;
  logic [15:0]        az_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= 31'd65536;
      center_x_q   <= '0;
      center_y_q   <= '0;
      center_z_q   <= '0;
      vert_steps_q <= StepW'(16);
      rad_steps_q  <= StepW'(32);
      az_offset_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_RADIUS:    radius_q     <= cfg_data_i[30:0];
        REG_CENTER_X:  center_x_q   <= cfg_data_i;
        REG_CENTER_Y:  center_y_q   <= cfg_data_i;
        REG_CENTER_Z:  center_z_q   <= cfg_data_i;
        REG_VERT_STEP: vert_steps_q <= cfg_data_i[StepW-1:0];
        REG_RAD_STEP:  rad_steps_q  <= cfg_data_i[StepW-1:0];
        REG_AZ_OFFSET: az_offset_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [StepW-1:0] rs, vs;
  assign rs = eff_steps(rad_steps_q);
  assign vs = eff_steps(vert_steps_q);

  // Pipeline advance: everything moves unless a finished corner is stalled.
  logic out_v_q, adv;
  assign adv = !out_v_q || out_if.ready;

  // Corner sequencer.
  logic            busy_q;
  logic [1:0]      cnt_q;
  logic [IdxW-1:0] ring_q, band_q;
  logic            take;

  assign in_if.ready = adv && (!busy_q || (cnt_q == 2'd3));
  assign take        = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (adv) begin
      if (take) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q  <= cnt_q + 2'd1;
        busy_q <= (cnt_q != 2'd3);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ring_q <= in_if.data.ring_index;
      band_q <= in_if.data.band_index;
    end
  end

  logic             d_az, d_lat;
  logic [StepW-1:0] ka, kl;
  assign d_az  = (cnt_q == 2'd2) || (cnt_q == 2'd3);
  assign d_lat = (cnt_q == 2'd1) || (cnt_q == 2'd2);
  assign ka    = {1'b0, ring_q} + StepW'(d_az);
  assign kl    = {1'b0, band_q} + StepW'(d_lat);

  // Division chain: azimuth k*2^32/rs and latitude k*2^31/vs.
  logic       div_v   [DivW+1];
  logic [1:0] div_c   [DivW+1];
  div_lane_t  div_az  [DivW+1];
  div_lane_t  div_lat [DivW+1];

  assign div_v[0]   = busy_q;
  assign div_c[0]   = cnt_q;
  assign div_az[0]  = '{rem: '0, word: {ka, 32'b0}};
  assign div_lat[0] = '{rem: '0, word: {1'b0, kl, 31'b0}};

  for (genvar g = 0; g < DivW; g++) begin : g_div
    sqvg_div_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (adv),
      .d_az_i   (rs),
      .d_lat_i  (vs),
      .valid_i  (div_v[g]),
      .corner_i (div_c[g]),
      .az_i     (div_az[g]),
      .lat_i    (div_lat[g]),
      .valid_o  (div_v[g+1]),
      .corner_o (div_c[g+1]),
      .az_o     (div_az[g+1]),
      .lat_o    (div_lat[g+1])
    );
  end

  logic [DivW-1:0] qa, ql;
  logic [31:0]     paz, plat, pa_f, pl_f;
  logic            neg_a, neg_l;
  logic [31:0]     pa_t, pl_t;

  assign qa    = div_az[DivW].word;
  assign ql    = div_lat[DivW].word;
  assign paz   = {az_offset_q, 16'b0} + qa[31:0];
  assign plat  = 32'hC000_0000 + ql[31:0];
  assign pa_t  = paz + 32'h4000_0000;
  assign pl_t  = plat + 32'h4000_0000;
  assign neg_a = pa_t[31];
  assign neg_l = pl_t[31];
  assign pa_f  = neg_a ? paz + 32'h8000_0000 : paz;
  assign pl_f  = neg_l ? plat + 32'h8000_0000 : plat;

  // CORDIC chain.
  logic     cor_v   [CORDIC_STAGES+1];
  cor_tag_t cor_tag [CORDIC_STAGES+1];
  rot_t     cor_lat [CORDIC_STAGES+1];
  rot_t     cor_az  [CORDIC_STAGES+1];

  assign cor_v[0]           = div_v[DivW];
  assign cor_tag[0].corner  = div_c[DivW];
  assign cor_tag[0].tex_u   = (qa[42:16] > 27'd65536) ? 17'd65536 : qa[32:16];
  assign cor_tag[0].tex_v   = (ql[42:15] > 28'd65536) ? 17'd65536 : ql[31:15];
  assign cor_tag[0].neg_lat = neg_l;
  assign cor_tag[0].neg_az  = neg_a;
  assign cor_lat[0]         = '{x: CordicOne, y: '0, z: {{2{pl_f[31]}}, pl_f}};
  assign cor_az[0]          = '{x: CordicOne, y: '0, z: {{2{pa_f[31]}}, pa_f}};

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cor
    sqvg_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (cor_v[g]),
      .tag_i   (cor_tag[g]),
      .lat_i   (cor_lat[g]),
      .az_i    (cor_az[g]),
      .valid_o (cor_v[g+1]),
      .tag_o   (cor_tag[g+1]),
      .lat_o   (cor_lat[g+1]),
      .az_o    (cor_az[g+1])
    );
  end

  // Arithmetic stages.
  logic               sa_v_q, sb_v_q, sc_v_q;
  cor_tag_t           sa_tag_q, sb_tag_q, sc_tag_q;
  logic signed [31:0] cl_q, sl_q, ca_q, sn_q;
  logic signed [31:0] pxb_q, pyb_q, pzb_q, pxc_q, pyc_q, pzc_q;
  logic signed [63:0] rx_q, ry_q, rz_q;
  logic signed [31:0] rad_s;
  out_item_t          out_q;
  cor_tag_t           ft;

  assign rad_s = $signed({1'b0, radius_q});
  assign ft    = cor_tag[CORDIC_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_v_q  <= 1'b0;
      sb_v_q  <= 1'b0;
      sc_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      sa_v_q  <= cor_v[CORDIC_STAGES];
      sb_v_q  <= sa_v_q;
      sc_v_q  <= sb_v_q;
      out_v_q <= sc_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_tag_q <= ft;
      cl_q     <= clamp30(cor_lat[CORDIC_STAGES].x, ft.neg_lat);
      sl_q     <= clamp30(cor_lat[CORDIC_STAGES].y, ft.neg_lat);
      ca_q     <= clamp30(cor_az[CORDIC_STAGES].x, ft.neg_az);
      sn_q     <= clamp30(cor_az[CORDIC_STAGES].y, ft.neg_az);

      sb_tag_q <= sa_tag_q;
      pxb_q    <= mul30(cl_q, ca_q);
      pyb_q    <= sl_q;
      pzb_q    <= mul30(cl_q, sn_q);

      sc_tag_q <= sb_tag_q;
      pxc_q    <= pxb_q;
      pyc_q    <= pyb_q;
      pzc_q    <= pzb_q;
      rx_q     <= rad_s * pxb_q;
      ry_q     <= rad_s * pyb_q;
      rz_q     <= rad_s * pzb_q;

      out_q.corner      <= sc_tag_q.corner;
      out_q.pos_x       <= pos_sat(rx_q, center_x_q);
      out_q.pos_y       <= pos_sat(ry_q, center_y_q);
      out_q.pos_z       <= pos_sat(rz_q, center_z_q);
      out_q.norm_x      <= norm_sat(pxc_q);
      out_q.norm_y      <= norm_sat(pyc_q);
      out_q.norm_z      <= norm_sat(pzc_q);
      out_q.tex_u       <= sc_tag_q.tex_u;
      out_q.tex_v       <= sc_tag_q.tex_v;
      out_q.last_corner <= (sc_tag_q.corner == 2'd3);
    end
  end

  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;

endmodule

FILE: sv/sqvg_checker.sv
// ----------------------------------------------------------------------------
// sqvg_checker
// Port-level checks for the sphere vertex generator, bound to the top level.
// ----------------------------------------------------------------------------
module sqvg_checker import sqvg_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.last_corner == (out_data_i.corner == 2'd3)))
    else $error("last_corner disagrees with corner number");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.tex_u <= 17'd65536 && out_data_i.tex_v <= 17'd65536))
    else $error("texture coordinate above one");

  a_quad_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("quad accepted in consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled output beat changed");

endmodule

bind sphere_quad_vertex_generator sqvg_checker u_sqvg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);

FILE: test/tb_sphere_quad_vertex_generator.sv
// ----------------------------------------------------------------------------
// tb_sphere_quad_vertex_generator
// Drives quad index beats through the sphere vertex generator under random
// gaps and output stalls, and checks every corner beat field by field against
// a fixed-point model of the tessellation, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sphere_quad_vertex_generator;
  import sqvg_pkg::*;

  localparam int unsigned CordicStages = 16;
  localparam int unsigned PipeDepth = 47 + CordicStages;
  localparam longint unsigned CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  sqvg_stream_if #(.T(in_item_t)) in_if ();
  sqvg_stream_if #(.T(out_item_t)) out_if ();

  sphere_quad_vertex_generator #(.CORDIC_STAGES(CordicStages)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if(in_if.sink),
    .out_if(out_if.source)
  );

  longint m_radius;
  longint m_cx, m_cy, m_cz;
  longint m_vsteps, m_rsteps, m_azoff;

  in_item_t quad_q[$];
  out_item_t corner_q[$];
  int errors;
  int beats_in, beats_out;
  longint cycles;
  bit hold_sender;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint eff_steps(longint s);
    if (s == 0) return 1;
    if (s > MaxSteps) return MaxSteps;
    return s;
  endfunction

  function automatic void rotate(logic [31:0] phase, output longint c, output longint s);
    bit neg;
    longint x, y, z, nx;
    logic [31:0] atab [24];
    atab = '{32'h20000000, 32'h12e4051d, 32'h09fb385b, 32'h051111d4,
             32'h028b0d43, 32'h0145d7e1, 32'h00a2f61e, 32'h00517c55,
             32'h0028be53, 32'h00145f2e, 32'h000a2f98, 32'h000517cc,
             32'h00028be6, 32'h000145f3, 32'h0000a2f9, 32'h0000517c,
             32'h000028be, 32'h0000145f, 32'h00000a2f, 32'h00000517,
             32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051};
    neg = 1'b0;
    x = 652032874;
    y = 0;
    if (((phase + 32'h40000000) & 32'h80000000) != 0) begin
      phase = phase + 32'h80000000;
      neg = 1'b1;
    end
    z = longint'($signed(phase));
    for (int k = 0; k < CordicStages && k < 24; k++) begin
      if (z >= 0) begin
        nx = x - asr64(y, k);
        y = y + asr64(x, k);
        z = z - longint'(atab[k]);
      end else begin
        nx = x + asr64(y, k);
        y = y - asr64(x, k);
        z = z + longint'(atab[k]);
      end
      x = nx;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = clip(x, -(64'sd1 <<< 30), 64'sd1 <<< 30);
    s = clip(y, -(64'sd1 <<< 30), 64'sd1 <<< 30);
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return asr64(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic logic [16:0] tex_coord(longint k, longint steps);
    longint t;
    t = (k * 65536) / steps;
    return t > 65536 ? 17'd65536 : t[16:0];
  endfunction

  task automatic predict_corners(in_item_t q);
    int dlat [4];
    int daz [4];
    longint rs, vs, ka, kl, cl, sl, ca, sa, px, py, pz;
    logic [31:0] paz, plat;
    out_item_t o;
    dlat = '{0, 1, 1, 0};
    daz = '{0, 0, 1, 1};
    rs = eff_steps(m_rsteps);
    vs = eff_steps(m_vsteps);
    for (int n = 0; n < 4; n++) begin
      ka = longint'(q.ring_index) + daz[n];
      kl = longint'(q.band_index) + dlat[n];
      paz = 32'((m_azoff << 16) + ((ka << 32) / rs));
      plat = 32'(64'hC0000000 + ((kl << 31) / vs));
      rotate(plat, cl, sl);
      rotate(paz, ca, sa);
      px = mul_q30(cl, ca);
      py = sl;
      pz = mul_q30(cl, sa);
      o.corner = n[1:0];
      o.pos_x = 32'(clip(m_cx + mul_q30(m_radius, px), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
      o.pos_y = 32'(clip(m_cy + mul_q30(m_radius, py), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
      o.pos_z = 32'(clip(m_cz + mul_q30(m_radius, pz), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
      o.norm_x = 16'(clip(asr64(px + 16384, 15), -32768, 32767));
      o.norm_y = 16'(clip(asr64(py + 16384, 15), -32768, 32767));
      o.norm_z = 16'(clip(asr64(pz + 16384, 15), -32768, 32767));
      o.tex_u = tex_coord(ka, rs);
      o.tex_v = tex_coord(kl, vs);
      o.last_corner = (n == 3);
      corner_q.insert(corner_q.size(), o);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: the model runs on the accepted beat, under the current settings.
  int send_gap;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predict_corners(in_if.data);
        beats_in++;
      end
      if (in_if.valid && !in_if.ready) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (quad_q.size() > 0 && !hold_sender) begin
        in_if.data <= quad_q.pop_front();
        in_if.valid <= 1'b1;
        send_gap <= gap_len();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor with random output stalls.
  int stall;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      if (out_if.valid && out_if.ready) begin
        beats_out++;
        if (corner_q.size() == 0) begin
          errors++;
          $display("%0t unexpected corner beat %p", $time, out_if.data);
        end else if (corner_q[0] !== out_if.data) begin
          errors++;
          $display("%0t mismatch expected %p actual %p", $time, corner_q[0], out_if.data);
          void'(corner_q.pop_front());
        end else begin
          void'(corner_q.pop_front());
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall <= gap_len();
      end
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("tb_sphere_quad_vertex_generator failed");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_RADIUS: m_radius = longint'(val[30:0]);
      REG_CENTER_X: m_cx = longint'($signed(val));
      REG_CENTER_Y: m_cy = longint'($signed(val));
      REG_CENTER_Z: m_cz = longint'($signed(val));
      REG_VERT_STEP: m_vsteps = longint'(val[10:0]);
      REG_RAD_STEP: m_rsteps = longint'(val[10:0]);
      REG_AZ_OFFSET: m_azoff = longint'(val[15:0]);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Settled values are sampled on the falling edge, away from the driver.
  task automatic drain();
    do begin
      @(negedge clk_i);
    end while (quad_q.size() != 0 || in_if.valid || corner_q.size() != 0);
    repeat (PipeDepth + 8) @(posedge clk_i);
  endtask

  task automatic push_quad(int i, int j);
    in_item_t q;
    q.ring_index = i[9:0];
    q.band_index = j[9:0];
    quad_q.insert(quad_q.size(), q);
  endtask

  task automatic random_quads(int count);
    int rs, vs;
    rs = int'(eff_steps(m_rsteps));
    vs = int'(eff_steps(m_vsteps));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 8)
        push_quad($urandom_range(0, rs - 1), $urandom_range(0, vs - 1));
      else
        push_quad($urandom_range(0, 1023), $urandom_range(0, 1023));
    end
  endtask

  task automatic random_settings();
    write_reg(REG_RADIUS, $urandom_range(0, 9) < 7 ? $urandom_range(1, 32'h00400000)
                                                   : {1'b0, 31'($urandom())});
    write_reg(REG_CENTER_X, $urandom());
    write_reg(REG_CENTER_Y, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h000fffff));
    write_reg(REG_CENTER_Z, $urandom());
    write_reg(REG_VERT_STEP, $urandom_range(0, 2047));
    write_reg(REG_RAD_STEP, $urandom_range(0, 2047));
    write_reg(REG_AZ_OFFSET, $urandom_range(0, 65535));
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_RADIUS;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    cycles = 0;
    send_gap = 0;
    stall = 0;
    hold_sender = 1'b0;
    m_radius = 65536;
    m_cx = 0;
    m_cy = 0;
    m_cz = 0;
    m_vsteps = 16;
    m_rsteps = 32;
    m_azoff = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, poles, seam and out-of-range indexes.
    push_quad(0, 0);
    push_quad(31, 15);
    push_quad(16, 8);
    push_quad(1023, 1023);
    push_quad(32, 16);
    push_quad(1023, 0);
    push_quad(0, 1023);
    drain();
    write_reg(REG_RADIUS, 32'h7fffffff);
    write_reg(REG_CENTER_X, 32'h7fffffff);
    write_reg(REG_CENTER_Y, 32'h80000000);
    write_reg(REG_CENTER_Z, 32'h12345678);
    write_reg(REG_VERT_STEP, 0);
    write_reg(REG_RAD_STEP, 2047);
    write_reg(REG_AZ_OFFSET, 65535);
    push_quad(0, 0);
    push_quad(1023, 0);
    push_quad(512, 1);
    push_quad(1023, 1023);
    drain();
    write_reg(REG_RADIUS, 1);
    write_reg(REG_CENTER_X, 32'h80000000);
    write_reg(REG_CENTER_Z, 32'h7fffffff);
    write_reg(REG_VERT_STEP, 1024);
    write_reg(REG_RAD_STEP, 1);
    write_reg(REG_AZ_OFFSET, 0);
    push_quad(0, 0);
    push_quad(0, 1023);
    push_quad(1, 512);
    drain();
    write_reg(REG_RADIUS, 0);
    write_reg(REG_VERT_STEP, 1);
    write_reg(REG_RAD_STEP, 1024);
    push_quad(1023, 0);
    push_quad(700, 0);
    push_quad(341, 682);
    drain();

    // Random phases, one setting each.
    for (int ph = 0; ph < 6; ph++) begin
      random_settings();
      random_quads(20);
      if (ph == 2) begin
        wait (quad_q.size() <= 10);
        hold_sender = 1'b1;
        do begin
          @(negedge clk_i);
        end while (in_if.valid || corner_q.size() != 0);
        hold_sender = 1'b0;
      end
      random_quads(20);
      drain();
    end

    if (corner_q.size() != 0) begin
      errors++;
      $display("%0t missing corners expected %0d actual 0", $time, corner_q.size());
    end
    $display("quads in %0d, corners checked %0d, settings incl. extremes and wrap", beats_in,
             beats_out);
    $display("directed poles, seams, saturation, zero radius and clamped steps covered");
    if (errors == 0) begin
      $display("tb_sphere_quad_vertex_generator passed");
    end else begin
      $display("tb_sphere_quad_vertex_generator failed");
    end
    $finish;
  end

endmodule
